@@ src/tfm_pkg.sv @@
// Shared constants and types for the tangent frame matrix core.
// Used by tfm_unitize, tangent_frame_matrix_core and tfm_checker; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tfm_pkg;

  localparam int COORD_W  = 32;            // Q16.16 coordinates and results
  localparam int DIFF_W   = COORD_W + 1;   // point difference
  localparam int UNIT_W   = 32;            // Q2.30 unit components
  localparam int FRAC_W   = 30;
  localparam int NORM_W   = 31;            // normalized magnitude, below 2^31
  localparam int SUM_W    = 64;            // sum of three squares
  localparam int ROOT_W   = 32;
  localparam int REM_W    = ROOT_W + 3;
  localparam int BPS      = 2;             // root or quotient bits per stage
  localparam int SQ_STAGES  = ROOT_W / BPS;
  localparam int QUO_W      = 32;
  localparam int DIV_STAGES = QUO_W / BPS;
  localparam int UNIT_LAT   = 7 + SQ_STAGES + DIV_STAGES + 1;
  localparam int PROD_W   = 2 * UNIT_W;
  localparam int CROSS_W  = PROD_W - 1;
  localparam int SCALE_W  = 24;
  localparam int SPROD_W  = NORM_W + SCALE_W;

  localparam logic [SCALE_W-1:0]  AXIS_SCALE_RESET = 24'd65536;
  localparam logic [6:0]          UP_MUL    = 7'd100;
  localparam logic [UNIT_W+6:0]   UP_THRESH = 39'd99 << FRAC_W;
  localparam logic [SPROD_W-1:0]  RND_HALF  = 55'd1 << (FRAC_W - 1);
  localparam logic [COORD_W-1:0]  ID_ONE    = 32'd65536;

  typedef enum logic [1:0] {
    KIND_NEXT  = 2'd0,
    KIND_PREV  = 2'd1,
    KIND_NONE  = 2'd2,
    KIND_EMPTY = 2'd3
  } kind_t;

endpackage

`default_nettype wire

@@ src/tangent_frame_matrix_core.sv @@
// Channel  | Ports                                | Direction
// cfg      | cfg_valid, cfg_ready, cfg_axis_scale | in (write only)
// in       | in_valid, in_ready, in_kind, in_*    | in
// out      | out_valid, out_ready, out_*          | out
//
// One item enters per cycle while the pipeline is not stalled at its output.
// Most of the pipeline is three normalizers, each a 16-stage square root and 16-stage divider.
// Synchronous active-low reset clears the valid bits and sets axis_scale to 1.0.
// When the output register is full and not taken, the pipeline stalls only once
// an item reaches its last stage; bubbles ahead of it still advance.
// Depends on tfm_pkg and tfm_unitize.
`timescale 1ns / 1ps
`default_nettype none

module tangent_frame_matrix_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tfm_pkg::SCALE_W-1:0]          cfg_axis_scale,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           in_kind,
  input  logic signed [tfm_pkg::COORD_W-1:0]   in_point_x,
  input  logic signed [tfm_pkg::COORD_W-1:0]   in_point_y,
  input  logic signed [tfm_pkg::COORD_W-1:0]   in_point_z,
  input  logic signed [tfm_pkg::COORD_W-1:0]   in_neighbor_x,
  input  logic signed [tfm_pkg::COORD_W-1:0]   in_neighbor_y,
  input  logic signed [tfm_pkg::COORD_W-1:0]   in_neighbor_z,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [tfm_pkg::COORD_W-1:0]   out_normal_x,
  output logic signed [tfm_pkg::COORD_W-1:0]   out_normal_y,
  output logic signed [tfm_pkg::COORD_W-1:0]   out_normal_z,
  output logic signed [tfm_pkg::COORD_W-1:0]   out_binormal_x,
  output logic signed [tfm_pkg::COORD_W-1:0]   out_binormal_y,
  output logic signed [tfm_pkg::COORD_W-1:0]   out_binormal_z,
  output logic signed [tfm_pkg::COORD_W-1:0]   out_tangent_x,
  output logic signed [tfm_pkg::COORD_W-1:0]   out_tangent_y,
  output logic signed [tfm_pkg::COORD_W-1:0]   out_tangent_z,
  output logic signed [tfm_pkg::COORD_W-1:0]   out_origin_x,
  output logic signed [tfm_pkg::COORD_W-1:0]   out_origin_y,
  output logic signed [tfm_pkg::COORD_W-1:0]   out_origin_z
);
  import tfm_pkg::*;

  typedef logic [2:0][COORD_W-1:0] vec_t;
  typedef struct packed { kind_t kind; vec_t pt; } side_a_t;
  typedef struct packed { side_a_t base; vec_t tn; } side_b_t;
  typedef struct packed { side_b_t base; vec_t bn; } side_c_t;

  logic                 en;
  logic [SCALE_W-1:0]   axis_scale_r;

  // Difference stage.
  vec_t                 pt_in, nb_in;
  logic [2:0][DIFF_W-1:0] d_nxt, d_vec_r;
  logic                 d_vld_r;
  side_a_t              d_side_r;

  logic                 u1_vld, u2_vld, u3_vld;
  logic [2:0][UNIT_W-1:0] u1_vec, u2_vec, u3_vec;
  side_a_t              u1_side;
  side_b_t              u2_side;
  side_c_t              u3_side;

  // Up vector stage.
  logic [UNIT_W-1:0]    ty_abs;
  logic [UNIT_W+6:0]    ty_prod;
  logic [2:0][UNIT_W-1:0] up_nxt, up_vec_r;
  logic                 up_vld_r;
  side_b_t              up_side_r;

  // Cross product stages.
  logic signed [PROD_W-1:0] xp_r [6];
  logic                 x1_vld_r, x2_vld_r;
  side_c_t              x1_side_r, x2_side_r;
  logic [2:0][CROSS_W-1:0] x2_vec_r;

  // Scale stages.
  logic [8:0][UNIT_W-1:0]  ax_unit;
  logic [8:0][NORM_W-1:0]  s1_mag_r;
  logic [8:0]              s1_neg_r, s2_neg_r;
  logic [8:0][SPROD_W-1:0] s2_prod_r;
  logic [SPROD_W-1:0]      rnd;
  logic [COORD_W-1:0]      ax_res;
  logic                    s1_vld_r, s2_vld_r, s3_vld_r;
  kind_t                   s1_kind_r, s2_kind_r;
  vec_t                    s1_pt_r, s2_pt_r;
  logic [8:0][COORD_W-1:0] fin_nxt, fin_ax_r;
  vec_t                    fin_org_nxt, fin_org_r;

  logic                    out_vld_r;
  logic [8:0][COORD_W-1:0] out_ax_r;
  vec_t                    out_org_r;

  // Configuration register.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_scale_r <= AXIS_SCALE_RESET;
    end else if (cfg_valid) begin
      axis_scale_r <= cfg_axis_scale;
    end
  end

  // The whole pipeline moves unless a finished item is blocked at its last stage.
  assign en       = !s3_vld_r || !out_vld_r || out_ready;
  assign in_ready = en;

  always_comb begin
    pt_in[0] = in_point_x;
    pt_in[1] = in_point_y;
    pt_in[2] = in_point_z;
    nb_in[0] = in_neighbor_x;
    nb_in[1] = in_neighbor_y;
    nb_in[2] = in_neighbor_z;
    for (int i = 0; i < 3; i++) begin
      case (kind_t'(in_kind))
        KIND_NEXT: d_nxt[i] = {nb_in[i][COORD_W-1], nb_in[i]} - {pt_in[i][COORD_W-1], pt_in[i]};
        KIND_PREV: d_nxt[i] = {pt_in[i][COORD_W-1], pt_in[i]} - {nb_in[i][COORD_W-1], nb_in[i]};
        default:   d_nxt[i] = {pt_in[i][COORD_W-1], pt_in[i]};
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r  <= 1'b0;
      up_vld_r <= 1'b0;
      x1_vld_r <= 1'b0;
      x2_vld_r <= 1'b0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else if (en) begin
      d_vld_r  <= in_valid;
      up_vld_r <= u1_vld;
      x1_vld_r <= u2_vld;
      x2_vld_r <= x1_vld_r;
      s1_vld_r <= u3_vld;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_vec_r       <= d_nxt;
      d_side_r.kind <= kind_t'(in_kind);
      d_side_r.pt   <= pt_in;
    end
  end

  tfm_unitize #(
    .IN_W   (DIFF_W),
    .SIDE_W ($bits(side_a_t))
  ) u_unit_tan (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (d_vld_r),
    .in_vec    (d_vec_r),
    .in_side   (d_side_r),
    .out_valid (u1_vld),
    .out_vec   (u1_vec),
    .out_side  (u1_side)
  );

  // Up is Z when |t.y| >= 0.99, which makes cross(up, t) = (-ty, tx, 0);
  // otherwise up is Y and cross(up, t) = (tz, 0, -tx).
  always_comb begin
    ty_abs  = u1_vec[1][UNIT_W-1] ? (~u1_vec[1] + 1'b1) : u1_vec[1];
    ty_prod = ty_abs * UP_MUL;
    if (ty_prod >= UP_THRESH) begin
      up_nxt[0] = ~u1_vec[1] + 1'b1;
      up_nxt[1] = u1_vec[0];
      up_nxt[2] = '0;
    end else begin
      up_nxt[0] = u1_vec[2];
      up_nxt[1] = '0;
      up_nxt[2] = ~u1_vec[0] + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      up_vec_r       <= up_nxt;
      up_side_r.base <= u1_side;
      up_side_r.tn   <= u1_vec;
    end
  end

  tfm_unitize #(
    .IN_W   (UNIT_W),
    .SIDE_W ($bits(side_b_t))
  ) u_unit_bin (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (up_vld_r),
    .in_vec    (up_vec_r),
    .in_side   (up_side_r),
    .out_valid (u2_vld),
    .out_vec   (u2_vec),
    .out_side  (u2_side)
  );

  // cross(t, b), products first, differences in the next stage.
  always_ff @(posedge clk) begin
    if (en) begin
      xp_r[0] <= $signed(u2_side.tn[1]) * $signed(u2_vec[2]);
      xp_r[1] <= $signed(u2_side.tn[2]) * $signed(u2_vec[1]);
      xp_r[2] <= $signed(u2_side.tn[2]) * $signed(u2_vec[0]);
      xp_r[3] <= $signed(u2_side.tn[0]) * $signed(u2_vec[2]);
      xp_r[4] <= $signed(u2_side.tn[0]) * $signed(u2_vec[1]);
      xp_r[5] <= $signed(u2_side.tn[1]) * $signed(u2_vec[0]);
      x1_side_r.base <= u2_side;
      x1_side_r.bn   <= u2_vec;

      x2_vec_r[0] <= CROSS_W'(xp_r[0] - xp_r[1]);
      x2_vec_r[1] <= CROSS_W'(xp_r[2] - xp_r[3]);
      x2_vec_r[2] <= CROSS_W'(xp_r[4] - xp_r[5]);
      x2_side_r   <= x1_side_r;
    end
  end

  tfm_unitize #(
    .IN_W   (CROSS_W),
    .SIDE_W ($bits(side_c_t))
  ) u_unit_nrm (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (x2_vld_r),
    .in_vec    (x2_vec_r),
    .in_side   (x2_side_r),
    .out_valid (u3_vld),
    .out_vec   (u3_vec),
    .out_side  (u3_side)
  );

  // Axis order: normal, binormal, tangent.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ax_unit[i]     = u3_vec[i];
      ax_unit[3 + i] = u3_side.bn[i];
      ax_unit[6 + i] = u3_side.base.tn[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        s1_mag_r[k] <= ax_unit[k][UNIT_W-1] ? NORM_W'(~ax_unit[k] + 1'b1)
                                            : NORM_W'(ax_unit[k]);
        s1_neg_r[k] <= ax_unit[k][UNIT_W-1];
      end
      s1_kind_r <= u3_side.base.base.kind;
      s1_pt_r   <= u3_side.base.base.pt;

      for (int k = 0; k < 9; k++) begin
        s2_prod_r[k] <= s1_mag_r[k] * axis_scale_r;
      end
      s2_neg_r  <= s1_neg_r;
      s2_kind_r <= s1_kind_r;
      s2_pt_r   <= s1_pt_r;
    end
  end

  // Round half away from zero on the magnitude; an empty line gives the identity.
  // The scaled magnitude stays below 2^24, so the signed range is never exceeded.
  always_comb begin
    rnd    = '0;
    ax_res = '0;
    for (int k = 0; k < 9; k++) begin
      rnd    = s2_prod_r[k] + RND_HALF;
      ax_res = COORD_W'(rnd[SPROD_W-1:FRAC_W]);
      fin_nxt[k] = s2_neg_r[k] ? (~ax_res + 1'b1) : ax_res;
    end
    fin_org_nxt = s2_pt_r;
    if (s2_kind_r == KIND_EMPTY) begin
      fin_nxt     = '0;
      fin_nxt[0]  = ID_ONE;
      fin_nxt[4]  = ID_ONE;
      fin_nxt[8]  = ID_ONE;
      fin_org_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_ax_r  <= fin_nxt;
      fin_org_r <= fin_org_nxt;
    end
  end

  // Output register: takes a valid last-stage item whenever the pipeline advances.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= s3_vld_r || (out_vld_r && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (en && s3_vld_r) begin
      out_ax_r  <= fin_ax_r;
      out_org_r <= fin_org_r;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_normal_x   = out_ax_r[0];
  assign out_normal_y   = out_ax_r[1];
  assign out_normal_z   = out_ax_r[2];
  assign out_binormal_x = out_ax_r[3];
  assign out_binormal_y = out_ax_r[4];
  assign out_binormal_z = out_ax_r[5];
  assign out_tangent_x  = out_ax_r[6];
  assign out_tangent_y  = out_ax_r[7];
  assign out_tangent_z  = out_ax_r[8];
  assign out_origin_x   = out_org_r[0];
  assign out_origin_y   = out_org_r[1];
  assign out_origin_z   = out_org_r[2];

endmodule

`default_nettype wire

@@ src/tfm_unitize.sv @@
// Pipelined vector normalizer: magnitude, shift normalize, square root, three dividers.
// Depends on tfm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tfm_unitize #(
  parameter int IN_W   = 33,
  parameter int SIDE_W = 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic [2:0][IN_W-1:0]              in_vec,
  input  logic [SIDE_W-1:0]                 in_side,
  output logic                              out_valid,
  output logic [2:0][tfm_pkg::UNIT_W-1:0]   out_vec,
  output logic [SIDE_W-1:0]                 out_side
);
  import tfm_pkg::*;

  localparam int MSB_W = $clog2(IN_W);

  logic [UNIT_LAT-1:0] vld_r;

  // Front stages: magnitude, maximum, leading one, normalize, squares, sum.
  logic [2:0][IN_W-1:0]       s1_mag_r, s2_mag_r, s3_mag_r, s4_mag_r;
  logic [2:0]                 s1_neg_r, s2_neg_r, s3_neg_r, s4_neg_r, s5_neg_r, s6_neg_r;
  logic [SIDE_W-1:0]          s1_side_r, s2_side_r, s3_side_r, s4_side_r, s5_side_r, s6_side_r;
  logic [IN_W-1:0]            s2_max_r, s3_mx_r;
  logic [MSB_W-1:0]           s4_msb_r, msb_nxt;
  logic                       s4_zero_r, s5_zero_r, s6_zero_r;
  logic [2:0][NORM_W-1:0]     s5_norm_r, s6_norm_r;
  logic [2:0][2*NORM_W-1:0]   s6_sq_r;

  // Square root stages; index 0 is the sum register.
  logic [SUM_W-1:0]           sq_x_r    [SQ_STAGES];
  logic [REM_W-1:0]           sq_rem_r  [SQ_STAGES];
  logic [ROOT_W-1:0]          sq_root_r [SQ_STAGES+1];
  logic [2:0][NORM_W-1:0]     sq_norm_r [SQ_STAGES+1];
  logic [2:0]                 sq_neg_r  [SQ_STAGES+1];
  logic                       sq_zero_r [SQ_STAGES+1];
  logic [SIDE_W-1:0]          sq_side_r [SQ_STAGES+1];

  // Divider stages.
  logic [2:0][ROOT_W-1:0]     dv_rem_r  [DIV_STAGES-1];
  logic [2:0][ROOT_W-1:0]     dv_nb_r   [DIV_STAGES-1];
  logic [2:0][QUO_W-1:0]      dv_q_r    [DIV_STAGES];
  logic [ROOT_W-1:0]          dv_dvs_r  [DIV_STAGES];
  logic [2:0]                 dv_neg_r  [DIV_STAGES];
  logic                       dv_zero_r [DIV_STAGES];
  logic [SIDE_W-1:0]          dv_side_r [DIV_STAGES];

  logic [2:0][UNIT_W-1:0]     out_vec_r;
  logic [SIDE_W-1:0]          out_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[UNIT_LAT-2:0], in_valid};
    end
  end

  always_comb begin
    msb_nxt = '0;
    for (int k = 0; k < IN_W; k++) begin
      if (s3_mx_r[k]) msb_nxt = MSB_W'(k);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_mag_r[i] <= in_vec[i][IN_W-1] ? (~in_vec[i] + 1'b1) : in_vec[i];
        s1_neg_r[i] <= in_vec[i][IN_W-1];
      end
      s1_side_r <= in_side;

      s2_max_r  <= (s1_mag_r[0] > s1_mag_r[1]) ? s1_mag_r[0] : s1_mag_r[1];
      s2_mag_r  <= s1_mag_r;
      s2_neg_r  <= s1_neg_r;
      s2_side_r <= s1_side_r;

      s3_mx_r   <= (s2_max_r > s2_mag_r[2]) ? s2_max_r : s2_mag_r[2];
      s3_mag_r  <= s2_mag_r;
      s3_neg_r  <= s2_neg_r;
      s3_side_r <= s2_side_r;

      s4_msb_r  <= msb_nxt;
      s4_zero_r <= (s3_mx_r == '0);
      s4_mag_r  <= s3_mag_r;
      s4_neg_r  <= s3_neg_r;
      s4_side_r <= s3_side_r;

      // Moving the largest leading one to bit 30 is a shift of a*2^30 right by its index.
      for (int i = 0; i < 3; i++) begin
        s5_norm_r[i] <= NORM_W'({s4_mag_r[i], {FRAC_W{1'b0}}} >> s4_msb_r);
      end
      s5_zero_r <= s4_zero_r;
      s5_neg_r  <= s4_neg_r;
      s5_side_r <= s4_side_r;

      for (int i = 0; i < 3; i++) begin
        s6_sq_r[i] <= s5_norm_r[i] * s5_norm_r[i];
      end
      s6_norm_r <= s5_norm_r;
      s6_zero_r <= s5_zero_r;
      s6_neg_r  <= s5_neg_r;
      s6_side_r <= s5_side_r;

      sq_x_r[0]    <= SUM_W'(s6_sq_r[0]) + SUM_W'(s6_sq_r[1]) + SUM_W'(s6_sq_r[2]);
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
      sq_norm_r[0] <= s6_norm_r;
      sq_neg_r[0]  <= s6_neg_r;
      sq_zero_r[0] <= s6_zero_r;
      sq_side_r[0] <= s6_side_r;
    end
  end

  // Restoring square root, two result bits per stage.
  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sqrt
    logic [REM_W-1:0]  rem_v;
    logic [REM_W-1:0]  trial;
    logic [ROOT_W-1:0] root_v;

    always_comb begin
      rem_v  = sq_rem_r[k];
      root_v = sq_root_r[k];
      trial  = '0;
      for (int b = 0; b < BPS; b++) begin
        rem_v = {rem_v[REM_W-3:0], sq_x_r[k][SUM_W-1-2*b -: 2]};
        trial = REM_W'({root_v, 2'b01});
        if (rem_v >= trial) begin
          rem_v  = rem_v - trial;
          root_v = {root_v[ROOT_W-2:0], 1'b1};
        end else begin
          root_v = {root_v[ROOT_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_root_r[k+1] <= root_v;
        sq_norm_r[k+1] <= sq_norm_r[k];
        sq_neg_r[k+1]  <= sq_neg_r[k];
        sq_zero_r[k+1] <= sq_zero_r[k];
        sq_side_r[k+1] <= sq_side_r[k];
      end
    end

    if (k < SQ_STAGES - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          sq_x_r[k+1]   <= sq_x_r[k] << (2 * BPS);
          sq_rem_r[k+1] <= rem_v;
        end
      end
    end
  end

  // Three restoring dividers, (norm * 2^30) / root, two quotient bits per stage.
  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
    logic [2:0][ROOT_W-1:0] src_rem, src_nb, rem_v, nb_v;
    logic [2:0][QUO_W-1:0]  src_q, q_v;
    logic [ROOT_W-1:0]      src_dvs;
    logic [2:0]             src_neg;
    logic                   src_zero;
    logic [SIDE_W-1:0]      src_side;
    logic [ROOT_W:0]        r2;

    if (j == 0) begin : g_src
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          src_rem[i] = ROOT_W'(sq_norm_r[SQ_STAGES][i] >> 2);
          src_nb[i]  = {sq_norm_r[SQ_STAGES][i][1:0], {(ROOT_W-2){1'b0}}};
        end
        src_q    = '0;
        src_dvs  = sq_root_r[SQ_STAGES];
        src_neg  = sq_neg_r[SQ_STAGES];
        src_zero = sq_zero_r[SQ_STAGES];
        src_side = sq_side_r[SQ_STAGES];
      end
    end else begin : g_src
      assign src_rem  = dv_rem_r[j-1];
      assign src_nb   = dv_nb_r[j-1];
      assign src_q    = dv_q_r[j-1];
      assign src_dvs  = dv_dvs_r[j-1];
      assign src_neg  = dv_neg_r[j-1];
      assign src_zero = dv_zero_r[j-1];
      assign src_side = dv_side_r[j-1];
    end

    always_comb begin
      rem_v = src_rem;
      nb_v  = src_nb;
      q_v   = src_q;
      r2    = '0;
      for (int i = 0; i < 3; i++) begin
        for (int b = 0; b < BPS; b++) begin
          r2       = {rem_v[i], nb_v[i][ROOT_W-1]};
          nb_v[i]  = {nb_v[i][ROOT_W-2:0], 1'b0};
          if (r2 >= {1'b0, src_dvs}) begin
            rem_v[i] = ROOT_W'(r2 - {1'b0, src_dvs});
            q_v[i]   = {q_v[i][QUO_W-2:0], 1'b1};
          end else begin
            rem_v[i] = r2[ROOT_W-1:0];
            q_v[i]   = {q_v[i][QUO_W-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_q_r[j]    <= q_v;
        dv_dvs_r[j]  <= src_dvs;
        dv_neg_r[j]  <= src_neg;
        dv_zero_r[j] <= src_zero;
        dv_side_r[j] <= src_side;
      end
    end

    if (j < DIV_STAGES - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          dv_rem_r[j] <= rem_v;
          dv_nb_r[j]  <= nb_v;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (dv_zero_r[DIV_STAGES-1]) begin
          out_vec_r[i] <= '0;
        end else if (dv_neg_r[DIV_STAGES-1][i]) begin
          out_vec_r[i] <= UNIT_W'(-dv_q_r[DIV_STAGES-1][i]);
        end else begin
          out_vec_r[i] <= UNIT_W'(dv_q_r[DIV_STAGES-1][i]);
        end
      end
      out_side_r <= dv_side_r[DIV_STAGES-1];
    end
  end

  assign out_valid = vld_r[UNIT_LAT-1];
  assign out_vec   = out_vec_r;
  assign out_side  = out_side_r;

endmodule

`default_nettype wire

@@ src/tfm_checker.sv @@
// Port-level checks for tangent_frame_matrix_core and the bind that attaches them.
// Depends on tfm_pkg and tangent_frame_matrix_core.
`timescale 1ns / 1ps
`default_nettype none

module tfm_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [tfm_pkg::COORD_W-1:0]  out_tangent_x,
  input logic signed [tfm_pkg::COORD_W-1:0]  out_origin_x
);
  import tfm_pkg::*;

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_tangent_x) && $stable(out_origin_x))
    else $error("result item changed while stalled");

  // Input is refused only when a finished item is blocked at the output.
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input refused without output back-pressure");

  // A unit axis scaled by a 24-bit Q8.16 factor stays within 2^24.
  a_axis_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_tangent_x <= 32'sd16777216) && (out_tangent_x >= -32'sd16777216))
    else $error("tangent component out of range");

endmodule

bind tangent_frame_matrix_core tfm_checker u_tfm_checker (.*);

`default_nettype wire
